FILE: sv/image_luminance_normalizer_defines.svh
// Assertion macros for the luminance normaliser.
`ifndef IMAGE_LUMINANCE_NORMALIZER_DEFINES_SVH
`define IMAGE_LUMINANCE_NORMALIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define ILN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ILN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ILN_ASSERT(lbl, prop, msg)
`define ILN_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: sv/ilnorm_pkg.sv
// Shared types, codes and constants of the luminance normaliser.
package ilnorm_pkg;

  localparam int VAL_W    = 26;
  localparam int IDX_W    = 10;
  localparam int PIX_W    = 8;
  localparam int DVD_W    = 64;
  localparam int DSR_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam int DEF_MAX_PIXELS = 1024;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic signed [63:0] VAL_MAX64 = 64'sd33554431;
  localparam logic signed [63:0] VAL_MIN64 = -64'sd33554432;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 26'sh1FFFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 26'sh2000000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > VAL_MAX64) r = VAL_MAX;
    else if (x < VAL_MIN64) r = VAL_MIN;
    else r = x[VAL_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/image_luminance_normalizer.sv
// Luminance normaliser top level: control, statistics and read path.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, opcode, pixel, last, index  | to block
//  out     | out_valid/out_ready, value, status             | from block
//  cfg     | cfg_we, cfg_index, cfg_wdata                   | to block
//
// Load: each pixel passes the 64-step shared divider (S_LDIV), then S_LACC; no new transfer is taken until then.
// Read: an error goes straight to S_OUT, an unscaled value passes S_RDWAIT, a scaled one also S_RDIV.
// Last pixel adds S_FIN (min-max), or S_FIN and then z-score: two divides, then the root.
// Reset is synchronous; the store needs no clearing pass.
// A result waiting on out_ready stalls only the next read at its final step.
`include "image_luminance_normalizer_defines.svh"
module image_luminance_normalizer #(
  parameter int MAX_PIXELS = ilnorm_pkg::DEF_MAX_PIXELS,
  parameter int FRAC_BITS  = ilnorm_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_opcode,
  input  logic [ilnorm_pkg::PIX_W-1:0]         in_pixel,
  input  logic                                 in_last_pixel,
  input  logic [ilnorm_pkg::IDX_W-1:0]         in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ilnorm_pkg::VAL_W-1:0]  out_value,
  output logic [1:0]                           out_status,
  input  logic                                 cfg_we,
  input  logic [ilnorm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ilnorm_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import ilnorm_pkg::*;

  localparam int AW    = $clog2(MAX_PIXELS);
  localparam int CW    = AW + 1;
  localparam int SUM_W = VAL_W + CW;
  localparam int IW    = (AW > IDX_W) ? AW : IDX_W;
  localparam logic signed [63:0] ONE_FX  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_FX = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_LDIV   = 12'b000000000010,
    S_LACC   = 12'b000000000100,
    S_FIN    = 12'b000000001000,
    S_MEAN   = 12'b000000010000,
    S_SQ     = 12'b000000100000,
    S_MSQ    = 12'b000001000000,
    S_VAR    = 12'b000010000000,
    S_SQRT   = 12'b000100000000,
    S_RDWAIT = 12'b001000000000,
    S_RDIV   = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  function automatic logic signed [VAL_W-1:0] post_val(input logic signed [63:0] r,
                                                       input logic inv);
    logic signed [63:0] t;
    t = inv ? (ONE_FX - r) : r;
    return sat_val(t);
  endfunction

  state_t state_r, state_nxt;

  // configuration and latched modes
  logic [PIX_W-1:0] zero_value_r, one_value_r;
  logic norm_en_r, use_std_r, invert_r;
  logic mode_norm_r, mode_inv_r;

  // statistics
  logic [CW-1:0]             cnt_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [63:0]               sq_r;
  logic signed [VAL_W-1:0]   min_r, max_r;
  logic signed [VAL_W-1:0]   offset_r;
  logic [DSR_W-1:0]          scale_r;
  logic                      image_ready_r;
  logic                      ld_last_r, ld_flat_r;

  // datapath payload
  logic signed [VAL_W-1:0]   v_r, mean_r, res_value_r, out_value_r;
  logic [1:0]                res_status_r, out_status_r;
  logic [63:0]               a_r, msq_r;
  logic                      sgn_r, out_valid_r;

  logic in_fire, full_c, in_range_c;
  logic [IW-1:0] idx_ext;

  // load operands
  logic signed [PIX_W:0] num_s, den_s, num_f;
  logic [PIX_W-1:0] num_mag, den_mag;
  logic [DVD_W-1:0] ld_dvd_c;

  // finalize and read operands
  logic [CW-1:0]           n_c;
  logic [SUM_W-1:0]        sum_mag_c;
  logic [63:0]             var_c;
  logic signed [VAL_W:0]   diff_c;
  logic [VAL_W:0]          diff_mag_c;
  logic [DVD_W-1:0]        rd_dvd_c;
  logic signed [63:0]      q_s, q_sgn_c;
  logic signed [2*VAL_W-1:0] vsq_c, msq_c;

  // shared units
  logic             div_start, div_neg_c;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DSR_W-1:0] div_dsr;
  unit_stat_t       div_st;
  logic             sqrt_start;
  logic [DSR_W-1:0] sqrt_root;
  unit_stat_t       sq_st;

  logic                 mem_we, mem_re;
  logic [VAL_W-1:0]     mem_rdata;
  logic signed [VAL_W-1:0] v_rd;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign idx_ext    = IW'(in_read_index);
  assign in_range_c = 32'(idx_ext) < 32'(cnt_r);
  assign full_c     = !image_ready_r && (cnt_r == CW'(MAX_PIXELS));

  assign num_s   = $signed({1'b0, in_pixel}) - $signed({1'b0, zero_value_r});
  assign den_s   = $signed({1'b0, one_value_r}) - $signed({1'b0, zero_value_r});
  assign num_f   = den_s[PIX_W] ? -num_s : num_s;
  assign den_mag = den_s[PIX_W] ? PIX_W'(-den_s) : den_s[PIX_W-1:0];
  assign num_mag = num_f[PIX_W] ? PIX_W'(-num_f) : num_f[PIX_W-1:0];
  assign ld_dvd_c = (DVD_W'(num_mag) << FRAC_BITS) + DVD_W'(den_mag >> 1);

  assign n_c       = (cnt_r == '0) ? CW'(1) : cnt_r;
  assign sum_mag_c = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign var_c     = (a_r > msq_r) ? (a_r - msq_r) : 64'd0;

  assign v_rd       = $signed(mem_rdata);
  assign diff_c     = {v_rd[VAL_W-1], v_rd} - {offset_r[VAL_W-1], offset_r};
  assign diff_mag_c = diff_c[VAL_W] ? (VAL_W+1)'(-diff_c) : diff_c;
  assign rd_dvd_c   = (DVD_W'(diff_mag_c) << FRAC_BITS) + DVD_W'(scale_r >> 1);

  assign q_s     = $signed(div_quo);
  assign q_sgn_c = sgn_r ? -q_s : q_s;
  assign vsq_c   = v_r * v_r;
  assign msq_c   = mean_r * mean_r;

  // operand selection for the shared divider, and the square-root start
  always_comb begin
    div_start  = 1'b0;
    div_neg_c  = 1'b0;
    div_dvd    = '0;
    div_dsr    = '0;
    sqrt_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_opcode == OP_LOAD && !full_c) begin
          div_start = 1'b1;
          div_neg_c = num_f[PIX_W];
          div_dvd   = ld_dvd_c;
          div_dsr   = DSR_W'(den_mag);
        end
      end
      S_FIN: begin
        if (use_std_r) begin
          div_start = 1'b1;
          div_neg_c = sum_r[SUM_W-1];
          div_dvd   = DVD_W'(sum_mag_c) + DVD_W'(n_c >> 1);
          div_dsr   = DSR_W'(n_c);
        end
      end
      S_MEAN: begin
        if (div_st.done) begin
          div_start = 1'b1;
          div_dvd   = sq_r + DVD_W'(n_c >> 1);
          div_dsr   = DSR_W'(n_c);
        end
      end
      S_VAR: sqrt_start = 1'b1;
      S_RDWAIT: begin
        if (mode_norm_r && scale_r != '0) begin
          div_start = 1'b1;
          div_neg_c = diff_c[VAL_W];
          div_dvd   = rd_dvd_c;
          div_dsr   = scale_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_LOAD) begin
            if (!full_c) state_nxt = S_LDIV;
            else if (in_last_pixel) state_nxt = S_FIN;
          end else if (image_ready_r && in_range_c) begin
            state_nxt = S_RDWAIT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_LDIV:   if (div_st.done) state_nxt = S_LACC;
      S_LACC:   state_nxt = ld_last_r ? S_FIN : S_IDLE;
      S_FIN:    state_nxt = use_std_r ? S_MEAN : S_IDLE;
      S_MEAN:   if (div_st.done) state_nxt = S_SQ;
      S_SQ:     if (div_st.done) state_nxt = S_MSQ;
      S_MSQ:    state_nxt = S_VAR;
      S_VAR:    state_nxt = S_SQRT;
      S_SQRT:   if (sq_st.done) state_nxt = S_IDLE;
      S_RDWAIT: state_nxt = (mode_norm_r && scale_r != '0) ? S_RDIV : S_OUT;
      S_RDIV:   if (div_st.done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign mem_we = (state_r == S_LACC);
  assign mem_re = in_fire && in_opcode == OP_READ;

  // control state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      zero_value_r  <= '0;
      one_value_r   <= 8'd255;
      norm_en_r     <= 1'b0;
      use_std_r     <= 1'b0;
      invert_r      <= 1'b0;
      mode_norm_r   <= 1'b0;
      mode_inv_r    <= 1'b0;
      cnt_r         <= '0;
      sum_r         <= '0;
      sq_r          <= '0;
      min_r         <= VAL_MAX;
      max_r         <= VAL_MIN;
      offset_r      <= '0;
      scale_r       <= '0;
      image_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZERO:   zero_value_r <= cfg_wdata;
          CFG_ONE:    one_value_r  <= cfg_wdata;
          CFG_NORM:   norm_en_r    <= cfg_wdata[0];
          CFG_STD:    use_std_r    <= cfg_wdata[0];
          CFG_INVERT: invert_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
      // a load after a finished image opens a new one
      if (in_fire && in_opcode == OP_LOAD && image_ready_r) begin
        cnt_r         <= '0;
        sum_r         <= '0;
        sq_r          <= '0;
        min_r         <= VAL_MAX;
        max_r         <= VAL_MIN;
        image_ready_r <= 1'b0;
      end
      if (state_r == S_LACC) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + SUM_W'(v_r);
        sq_r  <= sq_r + 64'(vsq_c);
        if (v_r < min_r) min_r <= v_r;
        if (v_r > max_r) max_r <= v_r;
      end
      if (state_r == S_FIN) begin
        mode_norm_r <= norm_en_r;
        mode_inv_r  <= invert_r;
        if (!use_std_r) begin
          offset_r      <= min_r;
          scale_r       <= (max_r > min_r) ? DSR_W'(max_r - min_r) : '0;
          image_ready_r <= 1'b1;
        end
      end
      if (state_r == S_SQRT && sq_st.done) begin
        offset_r      <= mean_r;
        scale_r       <= sqrt_root;
        image_ready_r <= 1'b1;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (div_start) sgn_r <= div_neg_c;
    if (in_fire) begin
      ld_last_r    <= in_last_pixel;
      ld_flat_r    <= (den_s == '0);
      res_value_r  <= '0;
      res_status_r <= image_ready_r ? ST_RANGE : ST_NOT_READY;
    end
    if (state_r == S_LDIV && div_st.done) begin
      v_r <= ld_flat_r ? '0 : sat_val(q_sgn_c);
    end
    if (state_r == S_MEAN && div_st.done) begin
      mean_r <= q_sgn_c[VAL_W-1:0];
    end
    if (state_r == S_SQ && div_st.done) a_r <= div_quo;
    if (state_r == S_MSQ) msq_r <= 64'(msq_c);
    if (state_r == S_RDWAIT) begin
      res_status_r <= ST_OK;
      if (!mode_norm_r) res_value_r <= post_val(64'(v_rd), mode_inv_r);
      else res_value_r <= post_val(HALF_FX, mode_inv_r);
    end
    if (state_r == S_RDIV && div_st.done) begin
      res_value_r <= post_val(q_sgn_c, mode_inv_r);
    end
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  ilnorm_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (v_r),
    .re    (mem_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (mem_rdata)
  );

  ilnorm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quo),
    .stat     (div_st)
  );

  ilnorm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (var_c),
    .root     (sqrt_root),
    .stat     (sq_st)
  );

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  `ILN_ASSERT(a_div_done_st,
    div_st.done |-> (state_r == S_LDIV || state_r == S_MEAN || state_r == S_SQ ||
                     state_r == S_RDIV),
    "divider finished with no consumer waiting")
  `ILN_ASSERT_NEVER(a_cnt_over, cnt_r > CW'(MAX_PIXELS), "pixel count beyond store depth")
  `ILN_ASSERT(a_ready_src,
    $rose(image_ready_r) |-> ($past(state_r) == S_FIN || $past(state_r) == S_SQRT),
    "image marked ready outside finalize")
  `ILN_ASSERT_NEVER(a_idle_busy, in_ready && (div_st.busy || sq_st.busy),
    "input taken while a unit is busy")
endmodule

FILE: sv/ilnorm_store.sv
// Pixel store: single-port write, registered read.
module ilnorm_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

FILE: sv/ilnorm_div.sv
// Restoring divider, one quotient bit per cycle.
module ilnorm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ilnorm_pkg::DVD_W-1:0] dividend,
  input  logic [ilnorm_pkg::DSR_W-1:0] divisor,
  output logic [ilnorm_pkg::DVD_W-1:0] quotient,
  output ilnorm_pkg::unit_stat_t    stat
);
  import ilnorm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W:0]   rem_sh;
  logic [DSR_W+1:0] trial;
  logic             take;

  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign take   = !trial[DSR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? trial[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], take};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

FILE: sv/ilnorm_sqrt.sv
// Integer square root, one root bit per cycle.
module ilnorm_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ilnorm_pkg::DVD_W-1:0] radicand,
  output logic [ilnorm_pkg::DSR_W-1:0] root,
  output ilnorm_pkg::unit_stat_t    stat
);
  import ilnorm_pkg::*;

  localparam int CNT_W = $clog2(DSR_W);

  logic [DVD_W-1:0] x_r;
  logic [DSR_W+1:0] rem_r;
  logic [DSR_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DSR_W+3:0] rem_sh;
  logic [DSR_W+3:0] trial;
  logic [DSR_W+3:0] diff;
  logic             take;

  assign rem_sh = {rem_r, x_r[DVD_W-1:DVD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DSR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[DVD_W-3:0], 2'b00};
      rem_r  <= take ? diff[DSR_W+1:0] : rem_sh[DSR_W+1:0];
      root_r <= {root_r[DSR_W-2:0], take};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
